// ===== src/tilt_complementary_filter_core_macros.svh =====
// assertion macros for the tilt complementary filter core
// expects clk_i and rst_ni in the scope of each use
`ifndef TILT_COMPLEMENTARY_FILTER_CORE_MACROS_SVH
`define TILT_COMPLEMENTARY_FILTER_CORE_MACROS_SVH

// same-cycle implication
`define TCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tcf_pkg.sv =====
// shared types, constants and helper functions of the tilt complementary filter
// no dependencies
package tcf_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int CW               = 34;  // cordic x/t datapath
  localparam int AW               = 32;  // angle width, Q16.16
  localparam int PRESCALE_SH      = 14;
  localparam int STEP_W           = 20;  // gyro step per sample
  localparam int SAT_W            = 34;
  localparam int CFG_W            = 24;
  localparam int CFG_IDX_W        = 2;

  localparam logic signed [AW-1:0] PI_Q16 = 32'sd205887;

  localparam logic [15:0] KEEP_RST  = 16'd64225;
  localparam logic [15:0] GAIN_RST  = 16'd1311;
  localparam logic [23:0] SCALE_RST = 24'd91600;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLE_KEEP    = 2'd0,
    REG_LOWPASS_GAIN = 2'd1,
    REG_GYRO_SCALE   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic                     clr;
    logic signed [STEP_W-1:0] step;
  } tcf_side_t;

  function automatic logic signed [AW-1:0] atan_q16(input logic [4:0] idx);
    logic signed [AW-1:0] r;
    case (idx)
      5'd0:    r = 32'sd51472;
      5'd1:    r = 32'sd30386;
      5'd2:    r = 32'sd16055;
      5'd3:    r = 32'sd8150;
      5'd4:    r = 32'sd4091;
      5'd5:    r = 32'sd2047;
      5'd6:    r = 32'sd1024;
      5'd7:    r = 32'sd512;
      5'd8:    r = 32'sd256;
      5'd9:    r = 32'sd128;
      5'd10:   r = 32'sd64;
      5'd11:   r = 32'sd32;
      5'd12:   r = 32'sd16;
      5'd13:   r = 32'sd8;
      5'd14:   r = 32'sd4;
      5'd15:   r = 32'sd2;
      5'd16:   r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic signed [AW-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [AW-1:0] r;
    if (v[SAT_W-1:AW-1] == '0 || v[SAT_W-1:AW-1] == '1) begin
      r = v[AW-1:0];
    end else if (v[SAT_W-1]) begin
      r = {1'b1, {(AW-1){1'b0}}};
    end else begin
      r = {1'b0, {(AW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== src/tcf_cordic.sv =====
// pipelined cordic vectoring unit: one rotation step per register stage
// depends on tcf_pkg
module tcf_cordic #(
  parameter int Steps = tcf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic signed [15:0]              y_i,
  input  logic signed [15:0]              z_i,
  input  tcf_pkg::tcf_side_t              side_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic                            zero_o,
  output logic signed [tcf_pkg::AW-1:0]   angle_o,
  output tcf_pkg::tcf_side_t              side_o
);
  import tcf_pkg::*;

  localparam int NS = (Steps > ATAN_ENTRIES) ? ATAN_ENTRIES : Steps;

  logic [NS:0]            v_q;
  logic [NS+1:0]          rdy;
  logic signed [CW-1:0]   x_q  [NS+1];
  logic signed [CW-1:0]   t_q  [NS+1];
  logic signed [AW-1:0]   a_q  [NS+1];
  logic [NS:0]            zv_q;
  tcf_side_t              s_q  [NS+1];

  logic signed [CW-1:0]   x0, t0, x_pre, t_pre;
  logic signed [AW-1:0]   a_pre;

  // prescale and fold the left half plane
  always_comb begin
    x0 = CW'(y_i) <<< PRESCALE_SH;
    t0 = CW'(z_i) <<< PRESCALE_SH;
    if (x0 < 0) begin
      a_pre = (t0 >= 0) ? PI_Q16 : -PI_Q16;
      x_pre = -x0;
      t_pre = -t0;
    end else begin
      a_pre = '0;
      x_pre = x0;
      t_pre = t0;
    end
  end

  assign rdy[NS+1] = ready_i;
  assign ready_o   = rdy[0];

  for (genvar k = 0; k <= NS; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      x_q[0]  <= x_pre;
      t_q[0]  <= t_pre;
      a_q[0]  <= a_pre;
      zv_q[0] <= (y_i == 16'sd0) && (z_i == 16'sd0);
      s_q[0]  <= side_i;
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_step
    localparam logic signed [AW-1:0] AtanK = atan_q16(5'(k - 1));
    logic signed [CW-1:0] xs, ts, x_d, t_d;
    logic signed [AW-1:0] a_d;

    always_comb begin
      xs = x_q[k-1] >>> (k - 1);
      ts = t_q[k-1] >>> (k - 1);
      if (t_q[k-1] > 0) begin
        x_d = x_q[k-1] + ts;
        t_d = t_q[k-1] - xs;
        a_d = a_q[k-1] + AtanK;
      end else begin
        x_d = x_q[k-1] - ts;
        t_d = t_q[k-1] + xs;
        a_d = a_q[k-1] - AtanK;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_q[k-1]) begin
        x_q[k]  <= x_d;
        t_q[k]  <= t_d;
        a_q[k]  <= a_d;
        zv_q[k] <= zv_q[k-1];
        s_q[k]  <= s_q[k-1];
      end
    end
  end

  assign valid_o = v_q[NS];
  assign zero_o  = zv_q[NS];
  assign angle_o = -a_q[NS];
  assign side_o  = s_q[NS];

endmodule

// ===== src/tilt_complementary_filter_core.sv =====
// path from input transaction to result valid: input, cordic (steps capped at 24),
//   product, filter, output registers; throughput: one item per cycle when not stalled
// the filter recursion closes within the filter stage, which sets the rate
// reset: all stage valids clear, filter state clears to zero, config regs take defaults
// depends on tcf_pkg, tcf_cordic and the assertion macro header
`include "tilt_complementary_filter_core_macros.svh"
module tilt_complementary_filter_core #(
  parameter int CordicSteps = tcf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             action_i,
  input  logic signed [15:0]               accel_y_i,
  input  logic signed [15:0]               accel_z_i,
  input  logic signed [15:0]               gyro_rate_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [31:0]               accel_angle_raw_o,
  output logic signed [31:0]               gyro_angle_raw_o,
  output logic signed [31:0]               accel_angle_lp_o,
  output logic signed [31:0]               gyro_angle_hp_o,
  output logic signed [31:0]               fused_angle_o,
  input  logic                             cfg_we_i,
  input  logic [tcf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tcf_pkg::CFG_W-1:0]        cfg_wdata_i
);
  import tcf_pkg::*;

  // configuration
  logic [15:0] keep_q, gain_q;
  logic [23:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q  <= KEEP_RST;
      gain_q  <= GAIN_RST;
      scale_q <= SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_POLE_KEEP:    keep_q  <= cfg_wdata_i[15:0];
        REG_LOWPASS_GAIN: gain_q  <= cfg_wdata_i[15:0];
        REG_GYRO_SCALE:   scale_q <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  // input register
  logic               s0_v_q, s0_act_q, s0_rdy, c_rdy;
  logic signed [15:0] s0_y_q, s0_z_q, s0_gr_q;

  assign s0_rdy     = !s0_v_q || c_rdy;
  assign in_stall_o = !s0_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (s0_rdy) begin
      s0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_rdy && in_valid_i) begin
      s0_act_q <= action_i;
      s0_y_q   <= accel_y_i;
      s0_z_q   <= accel_z_i;
      s0_gr_q  <= gyro_rate_i;
    end
  end

  // gyro step, floor(rate * scale / 2^20)
  logic signed [39:0] gyro_prod;
  tcf_side_t          s0_side;

  assign gyro_prod    = $signed({{24{s0_gr_q[15]}}, s0_gr_q}) * $signed({16'd0, scale_q});
  assign s0_side.clr  = s0_act_q;
  assign s0_side.step = gyro_prod[39:20];

  // accel angle
  logic                 c_v, c_zero, p_rdy;
  logic signed [AW-1:0] c_ang;
  tcf_side_t            c_side;

  tcf_cordic #(
    .Steps(CordicSteps)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s0_v_q),
    .ready_o (c_rdy),
    .y_i     (s0_y_q),
    .z_i     (s0_z_q),
    .side_i  (s0_side),
    .valid_o (c_v),
    .ready_i (p_rdy),
    .zero_o  (c_zero),
    .angle_o (c_ang),
    .side_o  (c_side)
  );

  // product stage: raw accel angle and its low-pass input term
  logic                 p_v_q, f_rdy;
  logic signed [AW-1:0] p_araw_q, p_araw_d;
  logic signed [48:0]   p_ga_q;
  tcf_side_t            p_side_q;

  assign p_rdy    = !p_v_q || f_rdy;
  assign p_araw_d = c_zero ? '0 : c_ang;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (p_rdy) begin
      p_v_q <= c_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_rdy && c_v) begin
      p_araw_q <= p_araw_d;
      p_ga_q   <= $signed({33'd0, gain_q}) * $signed({{17{p_araw_d[31]}}, p_araw_d});
      p_side_q <= c_side;
    end
  end

  // filter stage; its registers hold the filter state between items
  logic                 f_v_q, f_load, o_rdy;
  logic signed [AW-1:0] f_araw_q, f_graw_q, f_lp_q, f_hp_q;
  logic signed [AW-1:0] lp_d, hp_d, graw_d;
  logic signed [48:0]   lp_mul, hp_mul;
  logic signed [49:0]   lp_acc, hp_acc;
  logic signed [SAT_W-1:0] g_sum, g_diff;

  assign f_rdy  = !f_v_q || o_rdy;
  assign f_load = f_rdy && p_v_q;

  always_comb begin
    lp_mul = $signed({33'd0, keep_q}) * $signed({{17{f_lp_q[31]}}, f_lp_q});
    hp_mul = $signed({33'd0, keep_q}) * $signed({{17{f_hp_q[31]}}, f_hp_q});
    lp_acc = 50'(lp_mul) + 50'(p_ga_q) + 50'sd32768;
    lp_d   = sat32(lp_acc[49:16]);
    g_sum  = SAT_W'(f_graw_q) + SAT_W'($signed(p_side_q.step));
    graw_d = sat32(g_sum);
    g_diff = SAT_W'(graw_d) - SAT_W'(f_graw_q);
    hp_acc = 50'(hp_mul) + (50'(g_diff) <<< 16) + 50'sd32768;
    hp_d   = sat32(hp_acc[49:16]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q    <= 1'b0;
      f_araw_q <= '0;
      f_graw_q <= '0;
      f_lp_q   <= '0;
      f_hp_q   <= '0;
    end else begin
      if (f_rdy) begin
        f_v_q <= p_v_q;
      end
      if (f_load) begin
        if (p_side_q.clr) begin
          f_araw_q <= '0;
          f_graw_q <= '0;
          f_lp_q   <= '0;
          f_hp_q   <= '0;
        end else begin
          f_araw_q <= p_araw_q;
          f_graw_q <= graw_d;
          f_lp_q   <= lp_d;
          f_hp_q   <= hp_d;
        end
      end
    end
  end

  // output register
  logic                    o_v_q;
  logic signed [SAT_W-1:0] fused_sum;

  assign o_rdy     = !o_v_q || !out_stall_i;
  assign fused_sum = SAT_W'(f_lp_q) + SAT_W'(f_hp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (o_rdy) begin
      o_v_q <= f_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_rdy && f_v_q) begin
      accel_angle_raw_o <= f_araw_q;
      gyro_angle_raw_o  <= f_graw_q;
      accel_angle_lp_o  <= f_lp_q;
      gyro_angle_hp_o   <= f_hp_q;
      fused_angle_o     <= sat32(fused_sum);
    end
  end

  assign out_valid_o = o_v_q;

  // checks
  `TCF_ASSERT_NEXT(a_state_hold, !f_load,
    $stable(f_lp_q) && $stable(f_hp_q) && $stable(f_graw_q),
    "filter state changed without a transaction")
  `TCF_ASSERT_NEXT(a_clear_zero, f_load && p_side_q.clr,
    f_lp_q == '0 && f_hp_q == '0 && f_graw_q == '0,
    "clear item left filter state nonzero")
  `TCF_ASSERT_NOW(a_stall_full, in_stall_o,
    s0_v_q && !c_rdy,
    "input stalled while the input register could advance")

endmodule
